// File: sv/uqs_pkg.sv
package uqs_pkg;

    // position range of emitted offsets
    localparam int POS_BITS = 16;
    localparam logic [16:0] POS_LIMIT = (POS_BITS >= 16) ? 17'h0FFFF :
        17'((64'd1 << POS_BITS) - 64'd1);
    localparam logic [16:0] POS_NONE = 17'h1FFFF;

    // token queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_WITH_NUL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 2'd2;
    localparam int CFG_DATA_W = 16;

    // characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_DATA,
        OP_EQ,
        OP_DELIM
    } t_op;

    // one classified source byte
    typedef struct packed {
        logic       pre_semi;   // a held ';' turned out to be plain data
        t_op        op;
        logic [7:0] ch;
        logic       last;
    } t_token;

endpackage

// File: sv/uqs_front.sv
module uqs_front
    import uqs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  logic   [7:0] i_byte,
    input  logic   i_last,
    input  logic   i_header_mode,
    input  logic   i_q_full,
    output logic   o_stall,
    output logic   o_push,
    output t_token o_token
);

    typedef enum logic [1:0] {
        PD_NONE,
        PD_HEX1,
        PD_HEX2,
        PD_SEMI
    } t_pend;

    t_pend      r_pend;
    t_pend      n_pend;
    logic [3:0] r_hi_nib;
    logic [3:0] n_hi_nib;
    logic       plain;
    logic       accept;
    t_token     tok;

    function automatic logic [3:0] hexval(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end
        return v;
    endfunction

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        tok      = '0;
        tok.last = i_last;
        n_pend   = PD_NONE;
        n_hi_nib = r_hi_nib;
        plain    = 1'b0;

        unique case (r_pend)
            PD_HEX1: begin
                if (i_last) begin
                    tok.op = OP_DATA;
                    tok.ch = 8'h00;
                end else begin
                    n_hi_nib = hexval(i_byte);
                    n_pend   = PD_HEX2;
                end
            end
            PD_HEX2: begin
                tok.op   = OP_DATA;
                tok.ch   = {r_hi_nib, hexval(i_byte)};
                n_hi_nib = 4'd0;
            end
            PD_SEMI: begin
                if (i_byte == CH_SPACE) begin
                    tok.op = OP_DELIM;
                end else begin
                    tok.pre_semi = 1'b1;
                    plain        = 1'b1;
                end
            end
            default: plain = 1'b1;
        endcase

        if (plain) begin
            if (i_byte == CH_PLUS) begin
                tok.op = OP_DATA;
                tok.ch = CH_SPACE;
            end else if (i_byte == CH_AMP && !i_header_mode) begin
                tok.op = OP_DELIM;
            end else if (i_byte == CH_SEMI && i_header_mode) begin
                if (i_last) begin
                    tok.op = OP_DATA;
                    tok.ch = CH_SEMI;
                end else begin
                    n_pend = PD_SEMI;
                end
            end else if (i_byte == CH_EQ) begin
                tok.op = OP_EQ;
            end else if (i_byte == CH_PCT) begin
                if (i_last) begin
                    tok.op = OP_DATA;
                    tok.ch = 8'h00;
                end else begin
                    n_pend = PD_HEX1;
                end
            end else begin
                tok.op = OP_DATA;
                tok.ch = i_byte;
            end
        end

        // end of string drops any open escape or held ';'
        if (i_last) begin
            n_pend   = PD_NONE;
            n_hi_nib = 4'd0;
        end
    end

    // bytes that only set up an escape or a ';' need no back-end slot
    assign o_push  = accept && (tok.pre_semi || tok.op != OP_NONE || tok.last);
    assign o_token = tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= PD_NONE;
            r_hi_nib <= 4'd0;
        end else if (accept) begin
            r_pend   <= n_pend;
            r_hi_nib <= n_hi_nib;
        end
    end

endmodule

// File: sv/uqs_fifo.sv
module uqs_fifo
    import uqs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    input  logic   i_pop,
    output t_token o_head,
    output logic   o_empty,
    output logic   o_full
);

    t_token         r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QAW+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: sv/uqs_back.sv
module uqs_back
    import uqs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_token      i_head,
    output logic        o_pop,
    input  logic        i_split_with_nul,
    input  logic [15:0] i_start_offset,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic        o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic [16:0] o_name_pos,
    output logic [15:0] o_name_len,
    output logic [16:0] o_value_pos,
    output logic [15:0] o_value_len,
    output logic        o_overflow,
    output logic        o_out_last
);

    typedef enum logic [2:0] {
        M_DELIM,
        M_NAME,
        M_NAME_EQ,
        M_NULL_EQ,
        M_NAME_VAL,
        M_NULL_VAL
    } t_mode;

    // result slots of one token, in emission order
    typedef enum logic [2:0] {
        PH_SEMI,
        PH_MAIN,
        PH_FSEP1,
        PH_FONE,
        PH_FSEP2,
        PH_FREC,
        PH_DSEP,
        PH_DONE
    } t_phase;

    t_phase      r_phase;
    t_mode       r_mode;
    logic [15:0] r_count;
    logic        r_ovf;
    logic [16:0] r_name_start;
    logic [15:0] r_name_cnt;
    logic [16:0] r_value_start;
    logic [15:0] r_value_cnt;

    logic        r_out_valid;
    logic        r_out_kind;
    logic [7:0]  r_out_byte;
    logic [16:0] r_out_name_pos;
    logic [15:0] r_out_name_len;
    logic [16:0] r_out_value_pos;
    logic [15:0] r_out_value_len;
    logic        r_out_ovf;
    logic        r_out_last;

    t_mode       n_mode;
    logic [15:0] n_count;
    logic        n_ovf;
    logic [16:0] n_name_start;
    logic [15:0] n_name_cnt;
    logic [16:0] n_value_start;
    logic [15:0] n_value_cnt;

    t_phase      cur;
    t_phase      nxt;
    logic        advance;
    logic        work;
    logic        done;
    logic        is_rec;
    logic        emit;
    logic        dat;
    logic [7:0]  e_byte;
    logic [7:0]  sep;
    logic [16:0] sum;
    logic        ovf_now;
    logic [16:0] off;
    logic [16:0] rec_np;
    logic [15:0] rec_nl;
    logic [16:0] rec_vp;
    logic [15:0] rec_vl;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // first slot at or after 'from' that yields a result
    function automatic t_phase find_phase(input t_phase from, input t_token tok,
                                          input t_mode mode);
        logic   flush_on;
        logic   rec_md;
        t_phase ph;
        flush_on = tok.last || (tok.op == OP_DELIM);
        rec_md   = (mode == M_NAME) || (mode == M_NAME_EQ) ||
                   (mode == M_NAME_VAL) || (mode == M_NULL_VAL);
        if (from <= PH_SEMI && tok.pre_semi) begin
            ph = PH_SEMI;
        end else if (from <= PH_MAIN && (tok.op == OP_DATA || tok.op == OP_EQ)) begin
            ph = PH_MAIN;
        end else if (from <= PH_FSEP1 && flush_on && mode == M_NAME) begin
            ph = PH_FSEP1;
        end else if (from <= PH_FONE && flush_on && mode == M_NAME) begin
            ph = PH_FONE;
        end else if (from <= PH_FSEP2 && flush_on && mode == M_NAME) begin
            ph = PH_FSEP2;
        end else if (from <= PH_FREC && flush_on && rec_md) begin
            ph = PH_FREC;
        end else if (from <= PH_DSEP && tok.op == OP_DELIM) begin
            ph = PH_DSEP;
        end else begin
            ph = PH_DONE;
        end
        return ph;
    endfunction

    assign sep     = i_split_with_nul ? CH_NUL : CH_SPACE;
    assign advance = !r_out_valid || !i_out_stall;
    assign cur     = find_phase(r_phase, i_head, r_mode);
    assign work    = i_head_valid && (cur != PH_DONE) && advance;

    assign sum     = {1'b0, i_start_offset} + {1'b0, r_count};
    assign ovf_now = (sum > POS_LIMIT);
    assign off     = ovf_now ? POS_LIMIT : sum;

    assign rec_np  = (r_mode == M_NULL_VAL) ? POS_NONE : r_name_start;
    assign rec_nl  = (r_mode == M_NULL_VAL) ? 16'd0 : r_name_cnt;
    assign rec_vp  = (r_mode == M_NAME_EQ) ? POS_NONE : r_value_start;
    assign rec_vl  = (r_mode == M_NAME_EQ) ? 16'd0 : r_value_cnt;

    always_comb begin
        n_mode        = r_mode;
        n_count       = r_count;
        n_ovf         = r_ovf;
        n_name_start  = r_name_start;
        n_name_cnt    = r_name_cnt;
        n_value_start = r_value_start;
        n_value_cnt   = r_value_cnt;
        is_rec        = 1'b0;
        emit          = 1'b0;
        dat           = 1'b0;
        e_byte        = 8'h00;

        unique case (cur)
            PH_SEMI: begin
                dat    = 1'b1;
                e_byte = CH_SEMI;
            end
            PH_MAIN: begin
                if (i_head.op == OP_DATA) begin
                    dat    = 1'b1;
                    e_byte = i_head.ch;
                end else if (r_mode == M_NAME) begin
                    emit   = 1'b1;
                    e_byte = sep;
                    n_mode = M_NAME_EQ;
                end else if (r_mode == M_DELIM) begin
                    emit   = 1'b1;
                    e_byte = sep;
                    n_mode = M_NULL_EQ;
                end else begin
                    // '=' after the split is value data
                    dat    = 1'b1;
                    e_byte = CH_EQ;
                end
            end
            PH_FSEP1, PH_FSEP2: begin
                emit   = 1'b1;
                e_byte = sep;
            end
            PH_FONE: begin
                // bare name gets the inserted value "1"
                emit          = 1'b1;
                e_byte        = CH_ONE;
                n_value_start = off;
                n_value_cnt   = 16'd1;
            end
            PH_FREC: begin
                is_rec        = 1'b1;
                n_mode        = M_DELIM;
                n_name_start  = POS_NONE;
                n_name_cnt    = 16'd0;
                n_value_start = POS_NONE;
                n_value_cnt   = 16'd0;
            end
            PH_DSEP: begin
                emit          = 1'b1;
                e_byte        = sep;
                n_mode        = M_DELIM;
                n_name_start  = POS_NONE;
                n_name_cnt    = 16'd0;
                n_value_start = POS_NONE;
                n_value_cnt   = 16'd0;
            end
            default: ;
        endcase

        if (dat) begin
            emit = 1'b1;
            unique case (r_mode)
                M_NAME: n_name_cnt = sat_inc(r_name_cnt);
                M_NAME_EQ: begin
                    n_mode        = M_NAME_VAL;
                    n_value_start = off;
                    n_value_cnt   = 16'd1;
                end
                M_NULL_EQ: begin
                    n_mode        = M_NULL_VAL;
                    n_value_start = off;
                    n_value_cnt   = 16'd1;
                end
                M_NAME_VAL, M_NULL_VAL: n_value_cnt = sat_inc(r_value_cnt);
                default: begin
                    n_mode       = M_NAME;
                    n_name_start = off;
                    n_name_cnt   = 16'd1;
                end
            endcase
        end

        if (emit) begin
            n_count = sat_inc(r_count);
            n_ovf   = r_ovf | ovf_now;
        end
    end

    assign nxt   = find_phase(t_phase'(3'(cur) + 3'd1), i_head, n_mode);
    assign done  = (nxt == PH_DONE);
    assign o_pop = i_head_valid && ((cur == PH_DONE) || (advance && done));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_phase       <= PH_SEMI;
            r_mode        <= M_DELIM;
            r_count       <= 16'd0;
            r_ovf         <= 1'b0;
            r_name_start  <= POS_NONE;
            r_name_cnt    <= 16'd0;
            r_value_start <= POS_NONE;
            r_value_cnt   <= 16'd0;
        end else begin
            if (advance) begin
                r_out_valid <= work;
            end
            if (work) begin
                r_out_kind      <= is_rec;
                r_out_byte      <= is_rec ? 8'h00 : e_byte;
                r_out_name_pos  <= is_rec ? rec_np : 17'd0;
                r_out_name_len  <= is_rec ? rec_nl : 16'd0;
                r_out_value_pos <= is_rec ? rec_vp : 17'd0;
                r_out_value_len <= is_rec ? rec_vl : 16'd0;
                r_out_ovf       <= n_ovf;
                r_out_last      <= done && i_head.last;
            end
            if (o_pop) begin
                r_phase <= PH_SEMI;
            end else if (work) begin
                r_phase <= nxt;
            end
            // end of string: next string restarts at the start offset
            if (o_pop && i_head.last) begin
                r_mode        <= M_DELIM;
                r_count       <= 16'd0;
                r_ovf         <= 1'b0;
                r_name_start  <= POS_NONE;
                r_name_cnt    <= 16'd0;
                r_value_start <= POS_NONE;
                r_value_cnt   <= 16'd0;
            end else if (work) begin
                r_mode        <= n_mode;
                r_count       <= n_count;
                r_ovf         <= n_ovf;
                r_name_start  <= n_name_start;
                r_name_cnt    <= n_name_cnt;
                r_value_start <= n_value_start;
                r_value_cnt   <= n_value_cnt;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_name_pos  = r_out_name_pos;
    assign o_name_len  = r_out_name_len;
    assign o_value_pos = r_out_value_pos;
    assign o_value_len = r_out_value_len;
    assign o_overflow  = r_out_ovf;
    assign o_out_last  = r_out_last;

endmodule

// File: sv/url_query_unescape_splitter_core.sv
// The first result of a byte passes the token queue, then the back end's output register.
// Throughput: one byte per cycle while each byte yields at most one result and the output is
// not stalled; a byte with several results (pair record, bare-name "1" insertion) sends them
// one by one, paced by the back end's single output register. A 4-entry token queue absorbs it.
// Reset (synchronous, active low) clears the parse state and sets config registers to defaults.
module url_query_unescape_splitter_core
    import uqs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_in_last,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_out_kind,
    output logic [7:0]            o_out_byte,
    output logic signed [16:0]    o_name_pos,
    output logic [15:0]           o_name_len,
    output logic signed [16:0]    o_value_pos,
    output logic [15:0]           o_value_len,
    output logic                  o_overflow,
    output logic                  o_out_last
);

    logic        r_header_mode;
    logic        r_split_with_nul;
    logic [15:0] r_start_offset;

    logic        q_push;
    logic        q_pop;
    logic        q_empty;
    logic        q_full;
    t_token      q_in;
    t_token      q_head;
    logic [16:0] back_name_off;
    logic [16:0] back_value_off;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_mode    <= 1'b0;
            r_split_with_nul <= 1'b1;
            r_start_offset   <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_HEADER_MODE:    r_header_mode    <= i_cfg_data[0];
                CFG_SPLIT_WITH_NUL: r_split_with_nul <= i_cfg_data[0];
                CFG_START_OFFSET:   r_start_offset   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    uqs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_byte        (i_in_byte),
        .i_last        (i_in_last),
        .i_header_mode (r_header_mode),
        .i_q_full      (q_full),
        .o_stall       (o_in_stall),
        .o_push        (q_push),
        .o_token       (q_in)
    );

    uqs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_token (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    uqs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (!q_empty),
        .i_head           (q_head),
        .o_pop            (q_pop),
        .i_split_with_nul (r_split_with_nul),
        .i_start_offset   (r_start_offset),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_kind       (o_out_kind),
        .o_out_byte       (o_out_byte),
        .o_name_pos       (back_name_off),
        .o_name_len       (o_name_len),
        .o_value_pos      (back_value_off),
        .o_value_len      (o_value_len),
        .o_overflow       (o_overflow),
        .o_out_last       (o_out_last)
    );

    assign o_name_pos  = $signed(back_name_off);
    assign o_value_pos = $signed(back_value_off);

endmodule

// File: tb/tb_url_query_unescape_splitter_core.sv
`timescale 1ns / 1ps

module tb_url_query_unescape_splitter_core;
    import uqs_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 300;
    localparam int LONG_NAME_LEN = 24;

    typedef enum logic [2:0] {
        PM_DELIM,
        PM_NAME,
        PM_NAME_EQ,
        PM_NULL_EQ,
        PM_NAME_VAL,
        PM_NULL_VAL
    } t_parse_mode;

    typedef enum logic [1:0] {
        PK_NONE,
        PK_HEX1,
        PK_HEX2,
        PK_SEMI
    } t_pend;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
        logic [16:0] name_off;
        logic [15:0] name_len;
        logic [16:0] value_off;
        logic [15:0] value_len;
        logic        ovf;
        logic        last;
    } t_result;

    // Decoder state mirrored per string; due_q holds decoded bytes and pair records
    // still owed by the block, oldest first.
    class query_decoder;
        logic        cfg_header;
        logic        cfg_nul;
        logic [15:0] cfg_start;
        t_parse_mode mode;
        t_pend       pend;
        logic [3:0]  hi_nib;
        logic [15:0] out_cnt;
        logic        ovf;
        logic [16:0] name_at;
        logic [15:0] name_n;
        logic [16:0] val_at;
        logic [15:0] val_n;
        t_result     step_q[$];
        t_result     due_q[$];
        int          errors;

        function new();
            cfg_header = 1'b0;
            cfg_nul    = 1'b1;
            cfg_start  = '0;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            mode    = PM_DELIM;
            pend    = PK_NONE;
            hi_nib  = '0;
            out_cnt = '0;
            ovf     = 1'b0;
            clear_pair();
        endfunction

        function void clear_pair();
            name_at = POS_NONE;
            name_n  = '0;
            val_at  = POS_NONE;
            val_n   = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_HEADER_MODE:    cfg_header = d[0];
                CFG_SPLIT_WITH_NUL: cfg_nul    = d[0];
                CFG_START_OFFSET:   cfg_start  = d;
                default: ;
            endcase
        endfunction

        function logic [3:0] hex_nibble(logic [7:0] c);
            if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
            if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
            if (c >= "0" && c <= "9") return 4'(c - "0");
            return 4'd0;
        endfunction

        function logic [7:0] sep_char();
            return cfg_nul ? CH_NUL : CH_SPACE;
        endfunction

        // offset saturates at the position limit and raises the sticky flag
        function logic [16:0] emit(logic [7:0] c);
            int unsigned off;
            t_result r;
            off = cfg_start + out_cnt;
            if (off > POS_LIMIT) begin
                ovf = 1'b1;
                off = POS_LIMIT;
            end
            r = '0;
            r.ch = c;
            r.ovf = ovf;
            step_q.push_back(r);
            if (out_cnt != 16'hFFFF) out_cnt++;
            return off[16:0];
        endfunction

        function void flush_pair(t_parse_mode m);
            t_result r;
            case (m)
                PM_NAME: begin
                    // bare name gets an inserted "1" value
                    void'(emit(sep_char()));
                    val_at = emit(CH_ONE);
                    val_n  = 16'd1;
                    void'(emit(sep_char()));
                end
                PM_NAME_EQ: begin
                    val_at = POS_NONE;
                    val_n  = '0;
                end
                PM_NAME_VAL: ;
                PM_NULL_VAL: begin
                    name_at = POS_NONE;
                    name_n  = '0;
                end
                default: begin
                    clear_pair();
                    return;
                end
            endcase
            r = '0;
            r.kind      = 1'b1;
            r.name_off  = name_at;
            r.name_len  = name_n;
            r.value_off = val_at;
            r.value_len = val_n;
            r.ovf       = ovf;
            step_q.push_back(r);
            clear_pair();
        endfunction

        function void data_char(logic [7:0] c);
            logic [16:0] off;
            off = emit(c);
            case (mode)
                PM_NAME: if (name_n != 16'hFFFF) name_n++;
                PM_NAME_EQ, PM_NULL_EQ: begin
                    mode   = (mode == PM_NAME_EQ) ? PM_NAME_VAL : PM_NULL_VAL;
                    val_at = off;
                    val_n  = 16'd1;
                end
                PM_NAME_VAL, PM_NULL_VAL: if (val_n != 16'hFFFF) val_n++;
                default: begin
                    mode    = PM_NAME;
                    name_at = off;
                    name_n  = 16'd1;
                end
            endcase
        endfunction

        function void end_pair();
            t_parse_mode prev;
            prev = mode;
            mode = PM_DELIM;
            flush_pair(prev);
            void'(emit(sep_char()));
        endfunction

        function void plain_char(logic [7:0] c, logic last);
            if (c == CH_PLUS) begin
                data_char(CH_SPACE);
            end else if (c == CH_AMP && !cfg_header) begin
                end_pair();
            end else if (c == CH_SEMI && cfg_header) begin
                if (last) data_char(CH_SEMI);
                else pend = PK_SEMI;
            end else if (c == CH_EQ) begin
                if (mode == PM_NAME) begin
                    mode = PM_NAME_EQ;
                    void'(emit(sep_char()));
                end else if (mode == PM_DELIM) begin
                    mode = PM_NULL_EQ;
                    void'(emit(sep_char()));
                end else begin
                    data_char(CH_EQ);
                end
            end else if (c == CH_PCT) begin
                if (last) data_char(CH_NUL);
                else pend = PK_HEX1;
            end else begin
                data_char(c);
            end
        endfunction

        function void take_byte(logic [7:0] c, logic last);
            t_pend was;
            was = pend;
            pend = PK_NONE;
            step_q.delete();
            case (was)
                PK_HEX1: begin
                    if (last) data_char(CH_NUL);
                    else begin
                        hi_nib = hex_nibble(c);
                        pend   = PK_HEX2;
                    end
                end
                PK_HEX2: begin
                    data_char({hi_nib, hex_nibble(c)});
                    hi_nib = '0;
                end
                PK_SEMI: begin
                    if (c == CH_SPACE) end_pair();
                    else begin
                        data_char(CH_SEMI);
                        plain_char(c, last);
                    end
                end
                default: plain_char(c, last);
            endcase
            if (last) begin
                flush_pair(mode);
                if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
                restart();
            end
            foreach (step_q[k]) due_q.push_back(step_q[k]);
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (due_q.size() == 0) begin
                $error("unexpected result: kind %0d byte %h", got.kind, got.ch);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (got.kind !== want.kind) begin
                $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.ch !== want.ch) begin
                $error("out_byte: expected %h, got %h", want.ch, got.ch);
                errors++;
            end
            if (got.name_off !== want.name_off) begin
                $error("name_pos: expected %0d, got %0d",
                       $signed(want.name_off), $signed(got.name_off));
                errors++;
            end
            if (got.name_len !== want.name_len) begin
                $error("name_len: expected %0d, got %0d", want.name_len, got.name_len);
                errors++;
            end
            if (got.value_off !== want.value_off) begin
                $error("value_pos: expected %0d, got %0d",
                       $signed(want.value_off), $signed(got.value_off));
                errors++;
            end
            if (got.value_len !== want.value_len) begin
                $error("value_len: expected %0d, got %0d", want.value_len, got.value_len);
                errors++;
            end
            if (got.ovf !== want.ovf) begin
                $error("overflow: expected %0d, got %0d", want.ovf, got.ovf);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("out_last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_in_byte;
    logic                  i_in_last;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_out_kind;
    logic [7:0]            o_out_byte;
    logic signed [16:0]    o_name_pos;
    logic [15:0]           o_name_len;
    logic signed [16:0]    o_value_pos;
    logic [15:0]           o_value_len;
    logic                  o_overflow;
    logic                  o_out_last;

    url_query_unescape_splitter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_kind  (o_out_kind),
        .o_out_byte  (o_out_byte),
        .o_name_pos  (o_name_pos),
        .o_name_len  (o_name_len),
        .o_value_pos (o_value_pos),
        .o_value_len (o_value_len),
        .o_overflow  (o_overflow),
        .o_out_last  (o_out_last)
    );

    query_decoder dec;
    logic [7:0]   str_q[$];
    bit           idle_on;
    int           n_sent;
    int           stall_left;
    int           quiet_cycles;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // receiver backpressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind      = o_out_kind;
            got.ch        = o_out_byte;
            got.name_off  = o_name_pos;
            got.name_len  = o_name_len;
            got.value_off = o_value_pos;
            got.value_len = o_value_len;
            got.ovf       = o_overflow;
            got.last      = o_out_last;
            dec.match_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("url_query_unescape_splitter_core test failed");
            $finish;
        end
    end

    task automatic program_regs(logic hm, logic nul, logic [15:0] start);
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] d;
        for (int k = 0; k < 3; k++) begin
            case (k)
                0: begin
                    idx = CFG_HEADER_MODE;
                    d   = CFG_DATA_W'(hm);
                end
                1: begin
                    idx = CFG_SPLIT_WITH_NUL;
                    d   = CFG_DATA_W'(nul);
                end
                default: begin
                    idx = CFG_START_OFFSET;
                    d   = start;
                end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= d;
            do @(posedge i_clk); while (!o_cfg_ready);
            dec.set_reg(idx, d);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(logic [7:0] c, logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= c;
        i_in_last  <= last;
        do @(posedge i_clk); while (o_in_stall);
        dec.take_byte(c, last);
        n_sent++;
    endtask

    // sender holds off until every owed result has been transferred
    task automatic hold_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (dec.due_q.size() != 0);
    endtask

    task automatic send_str(int pause_at);
        for (int k = 0; k < str_q.size(); k++) begin
            send_byte(str_q[k], k == str_q.size() - 1);
            if (k == pause_at) hold_for_results();
        end
    endtask

    // bytes that produce nothing may still be in flight after the last owed result
    task automatic settle();
        hold_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_text(string s);
        for (int k = 0; k < s.len(); k++) str_q.push_back(s[k]);
    endtask

    function automatic logic [7:0] hex_char();
        int n;
        n = $urandom_range(0, 15);
        if (n < 10) return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
    endfunction

    function automatic void add_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            case ($urandom_range(0, 2))
                0:       str_q.push_back(8'("a" + $urandom_range(0, 25)));
                1:       str_q.push_back(8'("A" + $urandom_range(0, 25)));
                default: str_q.push_back(8'("0" + $urandom_range(0, 9)));
            endcase
        end else if (r < 60) begin
            str_q.push_back(CH_PLUS);
        end else if (r < 75) begin
            str_q.push_back(CH_PCT);
            str_q.push_back(hex_char());
            str_q.push_back(hex_char());
        end else if (r < 82) begin
            // escape with arbitrary digit bytes, delimiters included
            str_q.push_back(CH_PCT);
            str_q.push_back(8'($urandom_range(0, 255)));
            str_q.push_back(8'($urandom_range(0, 255)));
        end else if (r < 86) begin
            str_q.push_back(CH_SEMI);
        end else if (r < 89) begin
            str_q.push_back(CH_EQ);
        end else begin
            str_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void add_delim(logic hm);
        if (hm) begin
            str_q.push_back(CH_SEMI);
            str_q.push_back(CH_SPACE);
        end else begin
            str_q.push_back(CH_AMP);
        end
    endfunction

    // mostly well-formed pairs, sometimes with a broken tail or head
    function automatic void build_string(logic hm);
        int n_pairs;
        int shape;
        str_q.delete();
        n_pairs = $urandom_range(1, 5);
        for (int p = 0; p < n_pairs; p++) begin
            if (p != 0) add_delim(hm);
            shape = $urandom_range(0, 9);
            if (shape <= 6 || shape == 8) repeat ($urandom_range(1, 4)) add_char();
            if (shape <= 5 || shape == 7 || shape == 8) str_q.push_back(CH_EQ);
            if (shape <= 5 || shape == 7) repeat ($urandom_range(1, 4)) add_char();
        end
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
                0: str_q.push_back(CH_PCT);
                1: begin
                    str_q.push_back(CH_PCT);
                    str_q.push_back(hex_char());
                end
                2: str_q.push_back(CH_SEMI);
                3: begin
                    add_delim(hm);
                    add_delim(hm);
                end
                default: str_q.push_front(CH_EQ);
            endcase
        end
        if (str_q.size() == 0) str_q.push_back("x");
    endfunction

    initial begin
        int base;
        logic hm;
        logic [15:0] start;

        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_byte   <= '0;
        i_in_last   <= 1'b0;
        i_out_stall <= 1'b0;
        stall_left   = 0;
        quiet_cycles = 0;
        n_sent       = 0;
        idle_on      = 1'b1;
        dec = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // query mode: plus, escapes, "=val" whose escape eats a '&', empty pair,
        // bare name, "name="; pause mid-string until all results are out
        program_regs(1'b0, 1'b1, 16'h0000);
        str_q.delete();
        put_text("+=%4A&=%g&&&b&e=");
        send_str(7);
        settle();

        // header mode near the top of the offset range: lone semicolons, "; " split
        program_regs(1'b1, 1'b0, 16'hFFFD);
        str_q.delete();
        put_text("a;b; c;");
        send_str(-1);
        settle();

        // truncated escapes
        program_regs(1'b0, 1'b0, 16'hFFFF);
        str_q.delete();
        put_text("%4");
        send_str(-1);
        str_q.delete();
        put_text("%");
        send_str(-1);
        settle();

        base = n_sent;
        while (n_sent - base < RANDOM_ITEMS) begin
            hm = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
                0:       start = 16'h0000;
                1:       start = 16'hFFFF;
                2:       start = 16'hFFFF - 16'($urandom_range(0, 40));
                default: start = 16'($urandom_range(0, 65535));
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            program_regs(hm, 1'($urandom_range(0, 1)), start);
            repeat ($urandom_range(1, 4)) begin
                build_string(hm);
                if (str_q.size() > 2 && $urandom_range(0, 7) == 0)
                    send_str($urandom_range(0, str_q.size() - 2));
                else
                    send_str(-1);
            end
            settle();
        end

        // no idling from here: one long bare name, back to back
        idle_on = 1'b0;
        program_regs(1'b0, 1'b1, 16'hFFF0);
        str_q.delete();
        repeat (LONG_NAME_LEN) str_q.push_back("a");
        send_str(-1);
        settle();

        if (dec.errors == 0) begin
            $display("url_query_unescape_splitter_core test passed");
        end else begin
            $display("url_query_unescape_splitter_core test failed");
        end
        $finish;
    end

endmodule
